// File: design/ptws_pkg.sv
// Package for the perspective world-to-screen projection pipeline.
// Holds field widths, stage counts, reset values and register indexes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ptws_pkg;
	localparam int COORD_W  = 24;
	localparam int VP_BITS  = 12;
	localparam int MAT_W    = 16;
	localparam int ROW_W    = 48;
	localparam int TAN_W    = 24;
	localparam int SCR_W    = 21;
	localparam int REL_W    = COORD_W + 1;
	localparam int PROD_W   = REL_W + MAT_W;
	localparam int VIEW_W   = PROD_W + 2;
	localparam int NUM_W    = VIEW_W + VP_BITS + 20;
	localparam int DEN_W    = VIEW_W + TAN_W + 1;
	localparam int Q_W      = 23;
	localparam int REM_W    = DEN_W + Q_W + 1;
	localparam int DIV_ST   = Q_W + 1;
	localparam int XF_ST    = 3;
	localparam int PREP_ST  = 2;
	localparam int PIPE_ST  = XF_ST + PREP_ST + DIV_ST + 1;
	localparam int SUM_W    = SCR_W + 5;
	localparam logic [Q_W-1:0] OFF_CAP = Q_W'(1 << 22);
	localparam int CFG_IDX_W = 8;
	localparam int CFG_DAT_W = ROW_W;

	localparam logic [ROW_W-1:0] ROW0_RST = ROW_W'(48'd16384);
	localparam logic [ROW_W-1:0] ROW1_RST = ROW_W'(48'd1073741824);
	localparam logic [ROW_W-1:0] ROW2_RST = ROW_W'(48'd70368744177664);
	localparam logic [2*VP_BITS-1:0] VP_RST = (2*VP_BITS)'((1080 << VP_BITS) | 1920);
	localparam logic [TAN_W-1:0] TAN_RST = TAN_W'(45889);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CAM_X = 8'd0,
		REG_CAM_Y = 8'd1,
		REG_CAM_Z = 8'd2,
		REG_ROW0  = 8'd3,
		REG_ROW1  = 8'd4,
		REG_ROW2  = 8'd5,
		REG_VP    = 8'd6,
		REG_TAN   = 8'd7
	} reg_idx_t;

	// Sideband carried with each divider lane: sign of the numerator and visibility.
	typedef struct packed {
		logic neg;
		logic vis;
	} div_tag_t;
endpackage
`default_nettype wire

// File: design/ptws_xform.sv
// Camera-relative offset and 3x3 rotation, three pipeline stages.
// Depends on ptws_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ptws_xform import ptws_pkg::*; (
	input  wire                       clk,
	input  wire  [XF_ST-1:0]          en,
	input  wire  [COORD_W-1:0]        wx,
	input  wire  [COORD_W-1:0]        wy,
	input  wire  [COORD_W-1:0]        wz,
	input  wire  [COORD_W-1:0]        cam_x,
	input  wire  [COORD_W-1:0]        cam_y,
	input  wire  [COORD_W-1:0]        cam_z,
	input  wire  [ROW_W-1:0]          row0,
	input  wire  [ROW_W-1:0]          row1,
	input  wire  [ROW_W-1:0]          row2,
	output logic signed [VIEW_W-1:0]  vx_s3,
	output logic signed [VIEW_W-1:0]  vy_s3,
	output logic signed [VIEW_W-1:0]  vz_s3
);
	logic signed [REL_W-1:0]  rel_s1 [3];
	logic signed [PROD_W-1:0] prod_s2 [9];
	logic [ROW_W-1:0]         rows [3];

	assign rows[0] = row0;
	assign rows[1] = row1;
	assign rows[2] = row2;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			rel_s1[0] <= $signed({wx[COORD_W-1], wx}) - $signed({cam_x[COORD_W-1], cam_x});
			rel_s1[1] <= $signed({wy[COORD_W-1], wy}) - $signed({cam_y[COORD_W-1], cam_y});
			rel_s1[2] <= $signed({wz[COORD_W-1], wz}) - $signed({cam_z[COORD_W-1], cam_z});
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					prod_s2[3*r+c] <= PROD_W'(rel_s1[c] * $signed(rows[r][MAT_W*c +: MAT_W]));
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			vx_s3 <= VIEW_W'(prod_s2[0]) + VIEW_W'(prod_s2[1]) + VIEW_W'(prod_s2[2]);
			vy_s3 <= VIEW_W'(prod_s2[3]) + VIEW_W'(prod_s2[4]) + VIEW_W'(prod_s2[5]);
			vz_s3 <= VIEW_W'(prod_s2[6]) + VIEW_W'(prod_s2[7]) + VIEW_W'(prod_s2[8]);
		end
	end
endmodule
`default_nettype wire

// File: design/ptws_prep.sv
// Depth test, magnitudes and the dividend/divisor products, two stages.
// Depends on ptws_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ptws_prep import ptws_pkg::*; (
	input  wire                       clk,
	input  wire  [PREP_ST-1:0]        en,
	input  wire  signed [VIEW_W-1:0]  vx,
	input  wire  signed [VIEW_W-1:0]  vy,
	input  wire  signed [VIEW_W-1:0]  vz,
	input  wire  [VP_BITS-1:0]        h,
	input  wire  [TAN_W-1:0]          tan,
	output logic [NUM_W-1:0]          numx_s5,
	output logic [NUM_W-1:0]          numy_s5,
	output logic [DEN_W-1:0]          den_s5,
	output div_tag_t                  tagx_s5,
	output div_tag_t                  tagy_s5
);
	logic [VIEW_W-1:0] magx_s4, magy_s4, dep_s4;
	logic              negx_s4, negy_s4, vis_s4;
	logic [TAN_W-1:0]  t_eff;

	// A zero tangent behaves as the smallest step.
	assign t_eff = (tan == '0) ? TAN_W'(1) : tan;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			negx_s4 <= vx[VIEW_W-1];
			negy_s4 <= vy[VIEW_W-1];
			magx_s4 <= vx[VIEW_W-1] ? VIEW_W'(-vx) : VIEW_W'(vx);
			magy_s4 <= vy[VIEW_W-1] ? VIEW_W'(-vy) : VIEW_W'(vy);
			dep_s4  <= VIEW_W'(-vz);
			vis_s4  <= vz[VIEW_W-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			numx_s5 <= {(VIEW_W+VP_BITS)'(magx_s4 * (VIEW_W+VP_BITS)'(h)), 20'b0};
			numy_s5 <= {(VIEW_W+VP_BITS)'(magy_s4 * (VIEW_W+VP_BITS)'(h)), 20'b0};
			den_s5  <= {(DEN_W-1)'(dep_s4 * (DEN_W-1)'(t_eff)), 1'b0};
			tagx_s5 <= '{neg: negx_s4, vis: vis_s4};
			tagy_s5 <= '{neg: negy_s4, vis: vis_s4};
		end
	end
endmodule
`default_nettype wire

// File: design/ptws_div.sv
// Pipelined restoring divider, one quotient bit per stage, with an overflow stage.
// Depends on ptws_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ptws_div import ptws_pkg::*; (
	input  wire               clk,
	input  wire  [DIV_ST-1:0] en,
	input  wire  [NUM_W-1:0]  num,
	input  wire  [DEN_W-1:0]  den,
	input  div_tag_t          tag,
	output logic [Q_W-1:0]    quo,
	output logic              ovf,
	output div_tag_t          tag_out
);
	logic [NUM_W-1:0] rem_s [DIV_ST];
	logic [DEN_W-1:0] den_s [DIV_ST];
	logic [Q_W-1:0]   quo_s [DIV_ST];
	logic             ovf_s [DIV_ST];
	div_tag_t         tag_s [DIV_ST];

	// First stage flags a quotient of 2^23 or more; the result is capped anyway.
	always_ff @(posedge clk) begin
		if (en[0]) begin
			rem_s[0] <= num;
			den_s[0] <= den;
			quo_s[0] <= '0;
			ovf_s[0] <= REM_W'(num) >= (REM_W'(den) << Q_W);
			tag_s[0] <= tag;
		end
	end

	for (genvar k = 1; k < DIV_ST; k++) begin : g_bit
		logic [REM_W-1:0] trial;
		logic             take;
		assign trial = REM_W'(den_s[k-1]) << (Q_W - k);
		assign take  = !ovf_s[k-1] && (REM_W'(rem_s[k-1]) >= trial);
		always_ff @(posedge clk) begin
			if (en[k]) begin
				rem_s[k] <= take ? NUM_W'(REM_W'(rem_s[k-1]) - trial) : rem_s[k-1];
				quo_s[k] <= quo_s[k-1] | (take ? (Q_W'(1) << (Q_W - k)) : '0);
				den_s[k] <= den_s[k-1];
				ovf_s[k] <= ovf_s[k-1];
				tag_s[k] <= tag_s[k-1];
			end
		end
	end

	assign quo     = quo_s[DIV_ST-1];
	assign ovf     = ovf_s[DIV_ST-1];
	assign tag_out = tag_s[DIV_ST-1];
endmodule
`default_nettype wire

// File: design/ptws_out.sv
// Output stage: offset capping, sign, viewport centering, saturation and zeroing of hidden points.
// Depends on ptws_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ptws_out import ptws_pkg::*; (
	input  wire                 clk,
	input  wire                 en,
	input  wire  [Q_W-1:0]      qx,
	input  wire                 ovfx,
	input  div_tag_t            tagx,
	input  wire  [Q_W-1:0]      qy,
	input  wire                 ovfy,
	input  div_tag_t            tagy,
	input  wire  [VP_BITS-1:0]  w,
	input  wire  [VP_BITS-1:0]  h,
	output logic [SCR_W-1:0]    sx_q,
	output logic [SCR_W-1:0]    sy_q,
	output logic                vis_q
);
	logic [Q_W-1:0]          offx, offy;
	logic signed [SUM_W-1:0] soffx, soffy, sumx, sumy;

	function automatic logic [SCR_W-1:0] sat(input logic signed [SUM_W-1:0] v);
		logic signed [SUM_W-1:0] hi, lo;
		hi = SUM_W'((1 << (SCR_W-1)) - 1);
		lo = -SUM_W'(1 << (SCR_W-1));
		if (v > hi) return SCR_W'(hi);
		else if (v < lo) return SCR_W'(lo);
		else return SCR_W'(v);
	endfunction

	assign offx  = (ovfx || qx > OFF_CAP) ? OFF_CAP : qx;
	assign offy  = (ovfy || qy > OFF_CAP) ? OFF_CAP : qy;
	assign soffx = tagx.neg ? -$signed(SUM_W'(offx)) : $signed(SUM_W'(offx));
	assign soffy = tagy.neg ? -$signed(SUM_W'(offy)) : $signed(SUM_W'(offy));
	assign sumx  = $signed(SUM_W'({w, 3'b0})) + soffx;
	assign sumy  = $signed(SUM_W'({h, 3'b0})) - soffy;

	always_ff @(posedge clk) begin
		if (en) begin
			vis_q <= tagx.vis;
			sx_q  <= tagx.vis ? sat(sumx) : '0;
			sy_q  <= tagx.vis ? sat(sumy) : '0;
		end
	end
endmodule
`default_nettype wire

// File: design/perspective_world_to_screen_top.sv
// Top level of the perspective world-to-screen projection pipeline.
// Depends on ptws_pkg, ptws_xform, ptws_prep, ptws_div and ptws_out.
//
// Usage: world points arrive on the s_axis channel, one point per transaction,
// and each produces exactly one screen point transaction on m_axis. The camera
// position, the three rotation rows, the viewport size and the half field of
// view tangent are written through the cfg channel (index selects the register,
// data carries the value, upper unused bits are dropped). The cfg channel is
// always ready; write it only while no point is in flight.
//
// A new point is accepted every cycle unless a stall on m_axis_tready holds the
// pipeline. An accepted input reaches m_axis through three transform stages,
// two prep stages (depth test, then products), the 23-stage one-bit-per-stage
// divider plus its overflow stage, and the output register.
//
// Each stage has its own valid bit and moves when the stage after it is empty
// or moving, so a stall on m_axis_tready fills the bubbles upstream before
// s_axis_tready drops; nothing is lost or repeated.
//
// Reset clears every valid bit and returns the registers to an identity camera
// at the origin, a 1920x1080 viewport and a tangent of about 0.7002.
`timescale 1ns / 1ps
`default_nettype none
module perspective_world_to_screen_top import ptws_pkg::*; (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  s_axis_tvalid,
	output logic                 s_axis_tready,
	// world_x [23:0], world_y [47:24], world_z [71:48]
	input  wire  [71:0]          s_axis_tdata,
	output logic                 m_axis_tvalid,
	input  wire                  m_axis_tready,
	// screen_x [20:0], screen_y [41:21], zero fill [47:42]
	output logic [47:0]          m_axis_tdata,
	// visible [0]
	output logic                 m_axis_tuser,
	input  wire                  cfg_valid,
	output logic                 cfg_ready,
	input  wire  [CFG_IDX_W-1:0] cfg_index,
	input  wire  [CFG_DAT_W-1:0] cfg_data
);
	logic [COORD_W-1:0]   cam_x_q, cam_y_q, cam_z_q;
	logic [ROW_W-1:0]     row0_q, row1_q, row2_q;
	logic [2*VP_BITS-1:0] vp_q;
	logic [TAN_W-1:0]     tan_q;

	logic [PIPE_ST-1:0] vld_q;
	logic [PIPE_ST:0]   en;

	logic signed [VIEW_W-1:0] vx_s3, vy_s3, vz_s3;
	logic [NUM_W-1:0]         numx_s5, numy_s5;
	logic [DEN_W-1:0]         den_s5;
	div_tag_t                 tagx_s5, tagy_s5, tagx_d, tagy_d;
	logic [Q_W-1:0]           qx, qy;
	logic                     ovfx, ovfy;
	logic [SCR_W-1:0]         sx_q, sy_q;
	logic                     vis_q;

	// Configuration registers; writes are taken every cycle.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cam_x_q <= '0;
			cam_y_q <= '0;
			cam_z_q <= '0;
			row0_q  <= ROW0_RST;
			row1_q  <= ROW1_RST;
			row2_q  <= ROW2_RST;
			vp_q    <= VP_RST;
			tan_q   <= TAN_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_CAM_X: cam_x_q <= cfg_data[COORD_W-1:0];
				REG_CAM_Y: cam_y_q <= cfg_data[COORD_W-1:0];
				REG_CAM_Z: cam_z_q <= cfg_data[COORD_W-1:0];
				REG_ROW0:  row0_q  <= cfg_data[ROW_W-1:0];
				REG_ROW1:  row1_q  <= cfg_data[ROW_W-1:0];
				REG_ROW2:  row2_q  <= cfg_data[ROW_W-1:0];
				REG_VP:    vp_q    <= cfg_data[2*VP_BITS-1:0];
				REG_TAN:   tan_q   <= cfg_data[TAN_W-1:0];
				default: ;
			endcase
		end
	end

	// A stage advances when it is empty or the stage after it advances.
	always_comb begin
		en[PIPE_ST] = m_axis_tready;
		for (int k = PIPE_ST - 1; k >= 0; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) begin
				vld_q[0] <= s_axis_tvalid;
			end
			for (int k = 1; k < PIPE_ST; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign s_axis_tready = en[0];

	ptws_xform u_xform (
		.clk   (clk),
		.en    (en[XF_ST-1:0]),
		.wx    (s_axis_tdata[COORD_W-1:0]),
		.wy    (s_axis_tdata[2*COORD_W-1:COORD_W]),
		.wz    (s_axis_tdata[3*COORD_W-1:2*COORD_W]),
		.cam_x (cam_x_q),
		.cam_y (cam_y_q),
		.cam_z (cam_z_q),
		.row0  (row0_q),
		.row1  (row1_q),
		.row2  (row2_q),
		.vx_s3 (vx_s3),
		.vy_s3 (vy_s3),
		.vz_s3 (vz_s3)
	);

	ptws_prep u_prep (
		.clk     (clk),
		.en      (en[XF_ST+PREP_ST-1:XF_ST]),
		.vx      (vx_s3),
		.vy      (vy_s3),
		.vz      (vz_s3),
		.h       (vp_q[2*VP_BITS-1:VP_BITS]),
		.tan     (tan_q),
		.numx_s5 (numx_s5),
		.numy_s5 (numy_s5),
		.den_s5  (den_s5),
		.tagx_s5 (tagx_s5),
		.tagy_s5 (tagy_s5)
	);

	ptws_div u_div_x (
		.clk     (clk),
		.en      (en[XF_ST+PREP_ST+DIV_ST-1:XF_ST+PREP_ST]),
		.num     (numx_s5),
		.den     (den_s5),
		.tag     (tagx_s5),
		.quo     (qx),
		.ovf     (ovfx),
		.tag_out (tagx_d)
	);

	ptws_div u_div_y (
		.clk     (clk),
		.en      (en[XF_ST+PREP_ST+DIV_ST-1:XF_ST+PREP_ST]),
		.num     (numy_s5),
		.den     (den_s5),
		.tag     (tagy_s5),
		.quo     (qy),
		.ovf     (ovfy),
		.tag_out (tagy_d)
	);

	ptws_out u_out (
		.clk   (clk),
		.en    (en[PIPE_ST-1]),
		.qx    (qx),
		.ovfx  (ovfx),
		.tagx  (tagx_d),
		.qy    (qy),
		.ovfy  (ovfy),
		.tagy  (tagy_d),
		.w     (vp_q[VP_BITS-1:0]),
		.h     (vp_q[2*VP_BITS-1:VP_BITS]),
		.sx_q  (sx_q),
		.sy_q  (sy_q),
		.vis_q (vis_q)
	);

	assign m_axis_tvalid = vld_q[PIPE_ST-1];
	assign m_axis_tdata  = {6'b0, sy_q, sx_q};
	assign m_axis_tuser  = vis_q;
endmodule
`default_nettype wire

// File: design/ptws_checker.sv
// Port-level checks for the projection top level, attached by a bind.
// Depends on perspective_world_to_screen_top.
`timescale 1ns / 1ps
`default_nettype none
module ptws_port_props (
	input wire        clk,
	input wire        arst_n,
	input wire        m_axis_tvalid,
	input wire        m_axis_tready,
	input wire [47:0] m_axis_tdata,
	input wire        m_axis_tuser
);
	// A rejected point carries zero coordinates.
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == 48'd0))
		else $error("rejected point with nonzero coordinates");

	// No result is offered while reset is held.
	a_reset_idle: assert property (@(posedge clk) !arst_n |-> !m_axis_tvalid)
		else $error("result offered during reset");

	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
		else $error("result dropped while stalled");

	a_data_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> ($stable(m_axis_tdata) && $stable(m_axis_tuser)))
		else $error("result changed while stalled");
endmodule

bind perspective_world_to_screen_top ptws_port_props u_ptws_port_props (.*);
`default_nettype wire
